// ===== rtl/core/ecbp_pkg.sv =====
`default_nettype none

package ecbp_pkg;

    localparam int MAX_ARGS_DEF = 2;
    localparam int LEN_W        = 20;
    localparam int ARG_W        = 32;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

    // bytes seen in normal mode
    localparam logic [7:0] BYTE_LED_ON  = 8'h0E;
    localparam logic [7:0] BYTE_LED_OFF = 8'h0F;
    localparam logic [7:0] BYTE_ESC     = 8'h1B;

    // escape letters
    localparam logic [7:0] ESC_CLEAR    = 8'h63; // c
    localparam logic [7:0] ESC_ECHO     = 8'h45; // E
    localparam logic [7:0] ESC_RESET    = 8'h62; // b
    localparam logic [7:0] ESC_CURRENT  = 8'h42; // B
    localparam logic [7:0] ESC_LOAD     = 8'h4C; // L
    localparam logic [7:0] ESC_WRITE    = 8'h57; // W
    localparam logic [7:0] ESC_FILL     = 8'h46; // F
    localparam logic [7:0] ESC_SAVE     = 8'h21; // !
    localparam logic [7:0] ESC_GET      = 8'h3F; // ?
    localparam logic [7:0] ESC_DOWNLOAD = 8'h44; // D

    // argument syntax
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_HEX_A  = 8'h41;
    localparam logic [7:0] CH_HEX_F  = 8'h46;
    localparam logic [7:0] CH_HEX    = 8'h24; // $
    localparam logic [7:0] CH_LETTER = 8'h40; // @
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] HEX_A_OFS = 8'h37; // 'A' - 10

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_LED_ON  = 3'd1;
    localparam logic [2:0] EV_LED_OFF = 3'd2;
    localparam logic [2:0] EV_CLEAR   = 3'd3;
    localparam logic [2:0] EV_RESET   = 3'd4;
    localparam logic [2:0] EV_DATA    = 3'd5;
    localparam logic [2:0] EV_COMMAND = 3'd6;

    localparam logic [2:0] CODE_LOAD    = 3'd0;
    localparam logic [2:0] CODE_WRITE   = 3'd1;
    localparam logic [2:0] CODE_FILL    = 3'd2;
    localparam logic [2:0] CODE_GET     = 3'd3;
    localparam logic [2:0] CODE_SAVE    = 3'd4;
    localparam logic [2:0] CODE_CURRENT = 3'd5;

    typedef struct packed {
        logic [2:0]              event_res;
        logic [2:0]              command_code;
        logic signed [ARG_W-1:0] arg_first;
        logic signed [ARG_W-1:0] arg_second;
        logic [7:0]              data_byte;
        logic [LEN_W-1:0]        byte_index;
        logic                    download_last;
        logic                    echo_valid;
        logic [7:0]              echo_byte;
    } t_result;

    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] data;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/core/ecbp_parse.sv =====
`default_nettype none

module ecbp_parse #(
    parameter int MAX_ARGS = ecbp_pkg::MAX_ARGS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ecbp_pkg::t_cfg    i_cfg,
    input  wire logic              i_byte_valid,
    input  wire logic [7:0]        i_byte,
    output logic                   o_byte_take,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output ecbp_pkg::t_result      o_result
);

    localparam int IDX_W = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
    localparam int ARG_W = ecbp_pkg::ARG_W;
    localparam int LEN_W = ecbp_pkg::LEN_W;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_INT    = 2'd2,
        MODE_BIN    = 2'd3
    } t_mode;

    t_mode              r_mode, n_mode;
    logic [2:0]         r_cmd, n_cmd;
    logic [1:0]         r_pos, n_pos;
    logic [1:0]         r_total, n_total;
    logic               r_sign, n_sign;
    logic               r_hex, n_hex;
    logic [ARG_W-1:0]   r_args [MAX_ARGS];
    logic [ARG_W-1:0]   n_args [MAX_ARGS];
    logic [LEN_W-1:0]   r_left, n_left;
    logic [LEN_W-1:0]   r_dpos, n_dpos;
    logic               r_echo, n_echo;
    logic [LEN_W-1:0]   r_len;
    logic               r_out_valid;
    ecbp_pkg::t_result  r_result, n_result;

    logic               fire;
    logic [IDX_W-1:0]   slot;
    logic [ARG_W-1:0]   v;
    logic [ARG_W-1:0]   v_dec;
    logic [ARG_W-1:0]   v_hex;
    logic               digit;
    logic               hexlet;
    logic               advance;

    assign fire        = i_byte_valid && (!r_out_valid || i_out_ready);
    assign o_byte_take = fire;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    assign slot   = (int'(r_pos) < MAX_ARGS) ? IDX_W'(r_pos) : '0;
    assign digit  = (i_byte >= ecbp_pkg::CH_ZERO) && (i_byte <= ecbp_pkg::CH_NINE);
    assign hexlet = (i_byte >= ecbp_pkg::CH_HEX_A) && (i_byte <= ecbp_pkg::CH_HEX_F);
    assign v_dec  = (r_args[slot] << 3) + (r_args[slot] << 1)
                  + {24'd0, i_byte - ecbp_pkg::CH_ZERO};
    assign v_hex  = (r_args[slot] << 4)
                  + {24'd0, (digit ? i_byte - ecbp_pkg::CH_ZERO
                                   : i_byte - ecbp_pkg::HEX_A_OFS)};

    always_comb begin
        n_mode   = r_mode;
        n_cmd    = r_cmd;
        n_pos    = r_pos;
        n_total  = r_total;
        n_sign   = r_sign;
        n_hex    = r_hex;
        n_args   = r_args;
        n_left   = r_left;
        n_dpos   = r_dpos;
        n_echo   = r_echo;
        v        = r_args[slot];
        advance  = 1'b0;
        n_result = '0;
        n_result.echo_valid = r_echo;
        n_result.echo_byte  = r_echo ? i_byte : 8'd0;

        case (r_mode)
            MODE_NORMAL: begin
                if (i_byte == ecbp_pkg::BYTE_LED_ON) begin
                    n_result.event_res = ecbp_pkg::EV_LED_ON;
                end else if (i_byte == ecbp_pkg::BYTE_LED_OFF) begin
                    n_result.event_res = ecbp_pkg::EV_LED_OFF;
                end else if (i_byte == ecbp_pkg::BYTE_ESC) begin
                    n_mode = MODE_ESC;
                end
            end
            MODE_ESC: begin
                n_mode = MODE_NORMAL;
                case (i_byte)
                    ecbp_pkg::ESC_CLEAR:    n_result.event_res = ecbp_pkg::EV_CLEAR;
                    ecbp_pkg::ESC_ECHO:     n_echo = !r_echo;
                    ecbp_pkg::ESC_RESET:    n_result.event_res = ecbp_pkg::EV_RESET;
                    ecbp_pkg::ESC_CURRENT:  n_cmd = ecbp_pkg::CODE_CURRENT;
                    ecbp_pkg::ESC_LOAD:     n_cmd = ecbp_pkg::CODE_LOAD;
                    ecbp_pkg::ESC_WRITE:    n_cmd = ecbp_pkg::CODE_WRITE;
                    ecbp_pkg::ESC_FILL:     n_cmd = ecbp_pkg::CODE_FILL;
                    ecbp_pkg::ESC_SAVE:     n_cmd = ecbp_pkg::CODE_SAVE;
                    ecbp_pkg::ESC_GET:      n_cmd = ecbp_pkg::CODE_GET;
                    ecbp_pkg::ESC_DOWNLOAD: begin
                        n_left = r_len;
                        n_dpos = '0;
                        n_mode = MODE_BIN;
                    end
                    default: ;
                endcase
                if (i_byte == ecbp_pkg::ESC_CURRENT || i_byte == ecbp_pkg::ESC_LOAD
                        || i_byte == ecbp_pkg::ESC_WRITE || i_byte == ecbp_pkg::ESC_FILL
                        || i_byte == ecbp_pkg::ESC_SAVE || i_byte == ecbp_pkg::ESC_GET) begin
                    n_total = (i_byte == ecbp_pkg::ESC_SAVE) ? 2'd2 : 2'd1;
                    n_pos   = '0;
                    n_sign  = 1'b0;
                    n_hex   = 1'b0;
                    for (int i = 0; i < MAX_ARGS; i++) begin
                        n_args[i] = '0;
                    end
                    n_mode  = MODE_INT;
                end
            end
            MODE_INT: begin
                if (r_hex && (digit || hexlet)) begin
                    v = v_hex;
                end else if (!r_hex && digit) begin
                    v = v_dec;
                end else if (!r_hex && i_byte == ecbp_pkg::CH_MINUS) begin
                    n_sign = !r_sign;
                end else if (i_byte == ecbp_pkg::CH_HEX) begin
                    n_hex = 1'b1;
                end else if (i_byte == ecbp_pkg::CH_SEMI || i_byte == ecbp_pkg::CH_COMMA) begin
                    if (r_sign) begin
                        v = -r_args[slot];
                    end
                    advance = 1'b1;
                    n_hex   = 1'b0;
                end else if (!r_hex && i_byte >= ecbp_pkg::CH_LETTER) begin
                    v       = {24'd0, i_byte - ecbp_pkg::CH_LETTER};
                    advance = 1'b1;
                end else begin
                    n_mode = MODE_NORMAL;
                end
                n_args[slot] = v;
                if (advance) begin
                    n_pos = r_pos + 2'd1;
                    if (n_pos >= r_total) begin
                        n_result.event_res    = ecbp_pkg::EV_COMMAND;
                        n_result.command_code = r_cmd;
                        n_result.arg_first    = n_args[0];
                        if (r_cmd == ecbp_pkg::CODE_SAVE) begin
                            n_result.arg_second = n_args[IDX_W'(1)];
                        end
                        n_mode = MODE_NORMAL;
                    end
                end
            end
            MODE_BIN: begin
                n_result.event_res  = ecbp_pkg::EV_DATA;
                n_result.data_byte  = i_byte;
                n_result.byte_index = r_dpos;
                n_dpos = r_dpos + LEN_W'(1);
                n_left = r_left - LEN_W'(1);
                if (n_left == '0) begin
                    n_result.download_last = 1'b1;
                    n_mode = MODE_NORMAL;
                end
            end
            default: n_mode = MODE_NORMAL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_NORMAL;
            r_cmd       <= '0;
            r_pos       <= '0;
            r_total     <= '0;
            r_sign      <= 1'b0;
            r_hex       <= 1'b0;
            r_left      <= '0;
            r_dpos      <= '0;
            r_echo      <= 1'b0;
            r_len       <= ecbp_pkg::LEN_RESET;
            r_out_valid <= 1'b0;
            r_result    <= '0;
            for (int i = 0; i < MAX_ARGS; i++) begin
                r_args[i] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                r_len <= i_cfg.data;
            end
            if (fire) begin
                r_mode      <= n_mode;
                r_cmd       <= n_cmd;
                r_pos       <= n_pos;
                r_total     <= n_total;
                r_sign      <= n_sign;
                r_hex       <= n_hex;
                r_args      <= n_args;
                r_left      <= n_left;
                r_dpos      <= n_dpos;
                r_echo      <= n_echo;
                r_out_valid <= 1'b1;
                r_result    <= n_result;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_bin_gives_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_mode == MODE_BIN |=> r_out_valid && r_result.event_res == ecbp_pkg::EV_DATA)
        else $error("download byte did not produce a data word");

    a_last_only_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.download_last |-> r_result.event_res == ecbp_pkg::EV_DATA)
        else $error("last mark on a non-data word");

    a_echo_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_result.echo_valid |-> r_result.echo_byte == 8'd0)
        else $error("echo byte set while echo is off");

    a_cmd_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && n_result.event_res == ecbp_pkg::EV_COMMAND |=> r_mode == MODE_NORMAL)
        else $error("parser did not return to normal after a command");

    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire && !$past(!i_rst_n) |=> $stable(r_mode) && $stable(r_left))
        else $error("parser state moved without a word");

endmodule

`default_nettype wire

// ===== rtl/core/escape_command_byte_parser.sv =====
`default_nettype none

// Channel  | Direction | Handshake                     | Payload
// in       | input     | i_in_valid / o_in_ready       | i_rx_byte
// out      | output    | o_out_valid / i_out_ready     | o_event_res .. o_echo_byte
// cfg      | input     | i_cfg_valid / o_cfg_ready     | i_cfg_data (download_length)
//
// One word per cycle while out is ready; each word passes the input register, then the result register.
// Each word is parsed by combinational logic against the parser state; the widest step
// is the 32-bit multiply-by-ten/sixteen accumulate or the negate on a terminator.
// Reset (i_rst_n low, synchronous) clears the parser to normal mode, echo off,
// download length 1. A stalled out channel holds the result and backs up into in.

module escape_command_byte_parser #(
    parameter int MAX_ARGS = ecbp_pkg::MAX_ARGS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [7:0]                    i_rx_byte,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [2:0]                         o_event_res,
    output logic [2:0]                         o_command_code,
    output logic signed [ecbp_pkg::ARG_W-1:0]  o_arg_first,
    output logic signed [ecbp_pkg::ARG_W-1:0]  o_arg_second,
    output logic [7:0]                         o_data_byte,
    output logic [ecbp_pkg::LEN_W-1:0]         o_byte_index,
    output logic                               o_download_last,
    output logic                               o_echo_valid,
    output logic [7:0]                         o_echo_byte,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [ecbp_pkg::LEN_W-1:0]    i_cfg_data
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              take;
    ecbp_pkg::t_cfg    cfg;
    ecbp_pkg::t_result result;

    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.data    = i_cfg_data;
    assign o_in_ready  = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    ecbp_parse #(
        .MAX_ARGS(MAX_ARGS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_byte_valid(r_in_valid),
        .i_byte      (r_in_byte),
        .o_byte_take (take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_event_res     = result.event_res;
    assign o_command_code  = result.command_code;
    assign o_arg_first     = result.arg_first;
    assign o_arg_second    = result.arg_second;
    assign o_data_byte     = result.data_byte;
    assign o_byte_index    = result.byte_index;
    assign o_download_last = result.download_last;
    assign o_echo_valid    = result.echo_valid;
    assign o_echo_byte     = result.echo_byte;

endmodule

`default_nettype wire
